// ----- hw/rtl/chkvs_pkg.sv -----
// shared types and constants for the chained hash key-value store
// no dependencies
`default_nettype none
package chkvs_pkg;
   localparam int BUCKET_BITS = 17;
   localparam int NODE_COUNT  = 4096;
   localparam int BUCKETS     = 1 << BUCKET_BITS;
   localparam int LINK_W      = $clog2(NODE_COUNT + 1);
   localparam int NODE_W      = $clog2(NODE_COUNT);

   localparam logic MODE_PUT = 1'b0;
   localparam logic MODE_GET = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [63:0] key;
      logic [63:0] new_value;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [63:0] read_value;
      logic        pool_full;
   } rsp_type;
endpackage
`default_nettype wire

// ----- hw/rtl/chkvs_fifo.sv -----
// two-entry item queue between the front end and the chain walker
// depends on chkvs_pkg
`default_nettype none
module chkvs_fifo (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  chkvs_pkg::req_type push_data,
   output logic             full,
   input  wire              pop,
   output chkvs_pkg::req_type pop_data,
   output logic             not_empty
);
   import chkvs_pkg::*;

   req_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wr_ff <= ~wr_ff;
         if (pop && not_empty) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
      end
   end
endmodule
`default_nettype wire

// ----- hw/rtl/chkvs_walker.sv -----
// chain walker: bucket head table, node memories and pool allocator
// depends on chkvs_pkg
`default_nettype none
module chkvs_walker (
   input  wire               clock,
   input  wire               reset,
   input  wire               item_valid,
   input  chkvs_pkg::req_type item,
   output logic              item_pop,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output chkvs_pkg::rsp_type rsp_data,
   output logic              busy
);
   import chkvs_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HEAD, S_NODE, S_CHECK, S_DONE
   } state_type;

   logic [LINK_W-1:0] head_mem [BUCKETS];
   logic [63:0]       key_mem  [NODE_COUNT];
   logic [63:0]       val_mem  [NODE_COUNT];
   logic [LINK_W-1:0] next_mem [NODE_COUNT];

   state_type              state_ff;
   req_type                cur_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [BUCKET_BITS:0]   clr_ff;
   logic [LINK_W-1:0]      link_ff, last_ff, used_ff;
   logic [LINK_W:0]        steps_ff;
   logic [LINK_W-1:0]      head_rd_ff, next_rd_ff;
   logic [63:0]            key_rd_ff, val_rd_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [NODE_W-1:0] rd_idx;
   logic [NODE_W-1:0] new_idx;
   logic              link_ok;
   logic [NODE_W-1:0] upd_idx;
   logic [NODE_W-1:0] last_idx;
   logic              out_free;
   logic              rsp_fire;

   assign rd_idx   = NODE_W'(link_ff - 1'b1);
   assign new_idx  = NODE_W'(used_ff);
   assign upd_idx  = NODE_W'(link_ff - 1'b1);
   assign last_idx = NODE_W'(last_ff - 1'b1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign item_pop = (state_ff == S_IDLE) && item_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_fire  = (state_ff == S_CHECK) && !(link_ok && key_rd_ff != cur_ff.key)
                      && out_free;

   always_comb begin
      link_ok = (link_ff != '0) && (link_ff <= used_ff) && (steps_ff < (LINK_W+1)'(NODE_COUNT));
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[bucket_ff];
      key_rd_ff  <= key_mem[rd_idx];
      val_rd_ff  <= val_mem[rd_idx];
      next_rd_ff <= next_mem[rd_idx];

      if (state_ff == S_CLEAR) begin
         head_mem[clr_ff[BUCKET_BITS-1:0]] <= '0;
      end

      if (state_ff == S_CHECK && link_ok && key_rd_ff == cur_ff.key
          && cur_ff.mode == MODE_PUT) begin
         val_mem[upd_idx] <= cur_ff.new_value;
      end
      if (state_ff == S_CHECK && !(link_ok && key_rd_ff == cur_ff.key)
          && !link_ok && cur_ff.mode == MODE_PUT
          && used_ff < LINK_W'(NODE_COUNT)) begin
         key_mem[new_idx]  <= cur_ff.key;
         val_mem[new_idx]  <= cur_ff.new_value;
         next_mem[new_idx] <= '0;
         if (last_ff == '0) head_mem[bucket_ff] <= used_ff + 1'b1;
         else               next_mem[last_idx]  <= used_ff + 1'b1;
      end

      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_fire) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (BUCKET_BITS+1)'(BUCKETS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (item_valid) begin
                  cur_ff    <= item;
                  bucket_ff <= item.key[BUCKET_BITS-1:0];
                  state_ff  <= S_HEAD;
               end
            end
            S_HEAD: begin
               state_ff <= S_NODE;
            end
            S_NODE: begin
               link_ff  <= head_rd_ff;
               last_ff  <= '0;
               steps_ff <= '0;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (link_ok && key_rd_ff != cur_ff.key) begin
                  last_ff  <= link_ff;
                  link_ff  <= next_rd_ff;
                  steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_DONE;
               end else if (out_free) begin
                  rsp_ff.hit        <= link_ok;
                  rsp_ff.read_value <= (link_ok && cur_ff.mode == MODE_GET) ? val_rd_ff : '0;
                  rsp_ff.pool_full  <= !link_ok && cur_ff.mode == MODE_PUT
                                       && used_ff >= LINK_W'(NODE_COUNT);
                  if (!link_ok && cur_ff.mode == MODE_PUT && used_ff < LINK_W'(NODE_COUNT))
                     used_ff <= used_ff + 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) used_ff <= LINK_W'(NODE_COUNT))
      else $error("node count beyond pool");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pool_full |-> !rsp_ff.hit)
      else $error("hit and pool full together");
   assert property (@(posedge clock) disable iff (reset)
      item_pop |=> state_ff == S_HEAD)
      else $error("item taken without walk");
endmodule
`default_nettype wire

// ----- hw/rtl/chained_hash_key_value_store.sv -----
// chained hash key-value store: request queue in front of the chain walker
// after reset a pass over all 2^17 bucket heads clears them; no item is taken then
// the walker takes a new item only after it has offered the result of the last one; it reads
// the bucket head, then each chain node in turn until the key matches or the chain ends
// the two-entry queue takes items while the walker is busy
// depends on chkvs_pkg
`default_nettype none
module chained_hash_key_value_store (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  chkvs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output chkvs_pkg::rsp_type rsp_data
);
   import chkvs_pkg::*;

   logic    q_full, q_ne, q_pop, busy;
   req_type q_data;

   assign req_stall = q_full;

   chkvs_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(req_valid), .push_data(req_data), .full(q_full),
      .pop(q_pop), .pop_data(q_data), .not_empty(q_ne)
   );

   chkvs_walker u_walker (
      .clock(clock), .reset(reset),
      .item_valid(q_ne), .item(q_data), .item_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .busy(busy)
   );

   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_ne)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !busy)
      else $error("pop while walker busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");
endmodule
`default_nettype wire
